FILE: rtl/saqg_pkg.sv
`default_nettype none
package saqg_pkg;

	localparam int MaxSteps = 63;
	localparam int StepW = 7;
	localparam int CntW = 11;
	localparam int AngW = 20;
	localparam int RegW = 19;
	localparam int DurW = 24;
	localparam int TrigMin = 572;
	localparam int QShift = 16;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RELEASE,
		ST_ADVANCE,
		ST_MUL,
		ST_CLAMP,
		ST_GLIDE,
		ST_DIV,
		ST_POLY1,
		ST_POLY2,
		ST_BLEND,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		REG_POS_DZ,
		REG_POS_TRIG,
		REG_NEG_DZ,
		REG_NEG_TRIG,
		REG_HYST,
		REG_STEP_AMT,
		REG_MAX_EXTRA,
		REG_GLIDE_DUR
	} reg_idx_t;

	typedef struct packed {
		logic load;
		logic rel_step;
		logic adv_step;
		logic mul;
		logic clamp;
		logic glide;
		logic div_step;
		logic poly1;
		logic poly2;
		logic blend;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic rel_go;
		logic adv_go;
		logic instant;
		logic done_glide;
		logic div_last;
	} sts_t;

endpackage
`default_nettype wire

FILE: rtl/saqg_ctrl.sv
`default_nettype none
module saqg_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_fire,
	input  wire logic          out_free,
	input  wire saqg_pkg::sts_t sts,
	output saqg_pkg::cmd_t     cmd,
	output logic               busy
);

	saqg_pkg::state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= saqg_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			saqg_pkg::ST_IDLE: if (in_fire) state_next = saqg_pkg::ST_RELEASE;
			saqg_pkg::ST_RELEASE: if (!sts.rel_go) state_next = saqg_pkg::ST_ADVANCE;
			saqg_pkg::ST_ADVANCE: if (!sts.adv_go) state_next = saqg_pkg::ST_MUL;
			saqg_pkg::ST_MUL: state_next = saqg_pkg::ST_CLAMP;
			saqg_pkg::ST_CLAMP: state_next = saqg_pkg::ST_GLIDE;
			saqg_pkg::ST_GLIDE: begin
				if (sts.instant || sts.done_glide) state_next = saqg_pkg::ST_OUT;
				else state_next = saqg_pkg::ST_DIV;
			end
			saqg_pkg::ST_DIV: if (sts.div_last) state_next = saqg_pkg::ST_POLY1;
			saqg_pkg::ST_POLY1: state_next = saqg_pkg::ST_POLY2;
			saqg_pkg::ST_POLY2: state_next = saqg_pkg::ST_BLEND;
			saqg_pkg::ST_BLEND: state_next = saqg_pkg::ST_OUT;
			saqg_pkg::ST_OUT: if (out_free) state_next = saqg_pkg::ST_IDLE;
			default: state_next = saqg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != saqg_pkg::ST_IDLE);
		case (state_q)
			saqg_pkg::ST_IDLE: cmd.load = in_fire;
			saqg_pkg::ST_RELEASE: cmd.rel_step = sts.rel_go;
			saqg_pkg::ST_ADVANCE: cmd.adv_step = sts.adv_go;
			saqg_pkg::ST_MUL: cmd.mul = 1'b1;
			saqg_pkg::ST_CLAMP: cmd.clamp = 1'b1;
			saqg_pkg::ST_GLIDE: cmd.glide = 1'b1;
			saqg_pkg::ST_DIV: cmd.div_step = 1'b1;
			saqg_pkg::ST_POLY1: cmd.poly1 = 1'b1;
			saqg_pkg::ST_POLY2: cmd.poly2 = 1'b1;
			saqg_pkg::ST_BLEND: cmd.blend = 1'b1;
			saqg_pkg::ST_OUT: cmd.out_load = out_free;
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/saqg_dp.sv
`default_nettype none
module saqg_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire saqg_pkg::cmd_t              cmd,
	output saqg_pkg::sts_t                   sts,
	input  wire logic                        cfg_we,
	input  wire logic [2:0]                  cfg_index,
	input  wire logic [saqg_pkg::DurW-1:0]   cfg_data,
	input  wire logic signed [saqg_pkg::AngW-1:0] measured_angle,
	input  wire logic [19:0]                 elapsed_us,
	output logic signed [saqg_pkg::AngW-1:0] shown_angle,
	output logic signed [saqg_pkg::StepW-1:0] step_value
);

	localparam int RW = saqg_pkg::RegW;
	localparam int AW = saqg_pkg::AngW;
	localparam int DW = saqg_pkg::DurW;
	localparam int CW = saqg_pkg::CntW;
	localparam logic [25:0] TenthMul = 26'd6710887;
	localparam int TenthShift = 26;

	logic [RW-1:0] pos_dz_q, pos_trig_q, neg_dz_q, neg_trig_q;
	logic [RW-1:0] hyst_q, step_amt_q, max_extra_q;
	logic [DW-1:0] dur_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_dz_q <= '0;
			pos_trig_q <= RW'(6554);
			neg_dz_q <= '0;
			neg_trig_q <= RW'(6554);
			hyst_q <= '0;
			step_amt_q <= RW'(6554);
			max_extra_q <= '0;
			dur_q <= '0;
		end else if (cfg_we) begin
			case (saqg_pkg::reg_idx_t'(cfg_index))
				saqg_pkg::REG_POS_DZ: pos_dz_q <= cfg_data[RW-1:0];
				saqg_pkg::REG_POS_TRIG: pos_trig_q <= cfg_data[RW-1:0];
				saqg_pkg::REG_NEG_DZ: neg_dz_q <= cfg_data[RW-1:0];
				saqg_pkg::REG_NEG_TRIG: neg_trig_q <= cfg_data[RW-1:0];
				saqg_pkg::REG_HYST: hyst_q <= cfg_data[RW-1:0];
				saqg_pkg::REG_STEP_AMT: step_amt_q <= cfg_data[RW-1:0];
				saqg_pkg::REG_MAX_EXTRA: max_extra_q <= cfg_data[RW-1:0];
				saqg_pkg::REG_GLIDE_DUR: dur_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// floored triggers and hysteresis caps, caps taken at each input transfer
	logic [RW-1:0] ptrig, ntrig;
	logic [RW+3:0] pcap9, ncap9;
	logic [48:0] pcap_m, ncap_m;
	logic [RW-1:0] pcap, ncap;
	logic [RW-1:0] physt_q, nhyst_q;
	always_comb begin
		ptrig = (pos_trig_q < RW'(saqg_pkg::TrigMin)) ? RW'(saqg_pkg::TrigMin) : pos_trig_q;
		ntrig = (neg_trig_q < RW'(saqg_pkg::TrigMin)) ? RW'(saqg_pkg::TrigMin) : neg_trig_q;
		pcap9 = {ptrig, 3'b000} + (RW+4)'(ptrig);
		ncap9 = {ntrig, 3'b000} + (RW+4)'(ntrig);
		// divide by ten with a reciprocal multiply
		pcap_m = 49'(pcap9) * 49'(TenthMul);
		ncap_m = 49'(ncap9) * 49'(TenthMul);
		pcap = RW'(pcap_m >> TenthShift);
		ncap = RW'(ncap_m >> TenthShift);
	end

	// state
	logic signed [CW-1:0] cnt_q;
	logic signed [AW-1:0] disp_q, gstart_q, gtarget_q;
	logic [DW-1:0] gel_q;

	// per item working registers
	logic signed [AW-1:0] ang_q;
	logic [19:0] dt_q;
	logic signed [45:0] prod_q;
	logic signed [AW-1:0] tgt_q;
	logic [DW:0] rem_q;
	logic [16:0] tq_q;
	logic [4:0] dcnt_q;
	logic [33:0] tt_q;
	logic [17:0] ply_q;
	logic [16:0] p_q;
	logic signed [AW:0] delta_q;

	logic apos;
	logic [AW-1:0] amag;
	logic cpos;
	logic [CW-1:0] cmag;
	always_comb begin
		apos = !ang_q[AW-1];
		amag = apos ? ang_q : -ang_q;
		cpos = !cnt_q[CW-1];
		cmag = cpos ? cnt_q : -cnt_q;
	end

	logic [RW-1:0] trig_c, dz_c, trig_a, dz_a;
	always_comb begin
		trig_c = cpos ? ptrig : ntrig;
		dz_c = cpos ? pos_dz_q : neg_dz_q;
		trig_a = apos ? ptrig : ntrig;
		dz_a = apos ? pos_dz_q : neg_dz_q;
	end

	// thresholds from the current count
	logic [31:0] thr_rel_new, thr_adv_new;
	always_comb begin
		thr_rel_new = 32'(dz_c) + 32'(cmag) * 32'(trig_c);
		thr_adv_new = 32'(dz_a) + 32'(cmag + CW'(1)) * 32'(trig_a);
	end

	// release: sign*angle < dz + |c|*trig - hyst
	logic signed [33:0] rel_lhs;
	logic signed [33:0] rel_thr;
	logic signed [33:0] adv_thr;
	always_comb begin
		rel_lhs = cpos ? 34'(ang_q) : -34'(ang_q);
		rel_thr = $signed({2'b00, thr_rel_new}) - $signed({15'd0, cpos ? physt_q : nhyst_q});
		adv_thr = $signed({2'b00, thr_adv_new});
	end

	logic signed [CW-1:0] cnt_rel;
	always_comb begin
		cnt_rel = cpos ? cnt_q - CW'(1) : cnt_q + CW'(1);
	end

	logic [DW:0] gsum;
	logic [DW-1:0] gel_new;
	logic signed [AW:0] dtgt;
	logic signed [38:0] off;
	always_comb begin
		gsum = {1'b0, (tgt_q != gtarget_q) ? DW'(0) : gel_q} + (DW+1)'(dt_q);
		gel_new = (gsum > {1'b0, dur_q}) ? dur_q : gsum[DW-1:0];
		dtgt = (AW+1)'(tgt_q) - (AW+1)'((tgt_q != gtarget_q) ? disp_q : gstart_q);
		off = 39'(delta_q) * $signed({22'd0, p_q});
	end

	// restoring division of elapsed << 16 by duration; elapsed is below
	// duration, so the remainder starts at elapsed and 16 quotient bits remain
	logic [DW:0] rem_sh2, rem_try2;
	logic div_ge2;
	always_comb begin
		rem_sh2 = {rem_q[DW-1:0], 1'b0};
		rem_try2 = rem_sh2 - {1'b0, dur_q};
		div_ge2 = rem_sh2 >= {1'b0, dur_q};
	end

	always_comb begin
		sts.rel_go = (cnt_q != '0) && (rel_lhs < rel_thr);
		sts.adv_go = (cmag < CW'(saqg_pkg::MaxSteps)) &&
			(cnt_q == '0 || cpos == apos) &&
			($signed({14'd0, amag}) >= adv_thr);
		sts.instant = (dur_q == '0);
		sts.done_glide = (gel_new >= dur_q);
		sts.div_last = (dcnt_q == 5'd0);
	end

	logic signed [38:0] off_tr;
	always_comb begin
		off_tr = off[38] ? -((-off) >>> 16) : (off >>> 16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			disp_q <= '0;
			gstart_q <= '0;
			gtarget_q <= '0;
			gel_q <= '0;
		end else begin
			if (cmd.rel_step) cnt_q <= cnt_rel;
			if (cmd.adv_step) cnt_q <= apos ? cnt_q + CW'(1) : cnt_q - CW'(1);
			if (cmd.glide) begin
				if (sts.instant) begin
					disp_q <= tgt_q;
					gstart_q <= tgt_q;
					gtarget_q <= tgt_q;
					gel_q <= '0;
				end else begin
					if (tgt_q != gtarget_q) begin
						gstart_q <= disp_q;
						gtarget_q <= tgt_q;
					end
					gel_q <= gel_new;
					if (gel_new >= dur_q) disp_q <= tgt_q;
				end
			end
			if (cmd.blend) disp_q <= AW'(39'(gstart_q) + off_tr);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ang_q <= measured_angle;
			dt_q <= elapsed_us;
			physt_q <= (hyst_q < pcap) ? hyst_q : pcap;
			nhyst_q <= (hyst_q < ncap) ? hyst_q : ncap;
		end
		if (cmd.mul) prod_q <= 46'($signed(cnt_q)) * $signed({1'b0, step_amt_q});
		if (cmd.clamp) begin
			if (max_extra_q != '0 && prod_q > 46'($signed({1'b0, max_extra_q})))
				tgt_q <= AW'($signed({1'b0, max_extra_q}));
			else if (max_extra_q != '0 && prod_q < -46'($signed({1'b0, max_extra_q})))
				tgt_q <= -AW'($signed({1'b0, max_extra_q}));
			else if (prod_q > 46'sd524287) tgt_q <= AW'(524287);
			else if (prod_q < -46'sd524288) tgt_q <= AW'(-524288);
			else tgt_q <= AW'(prod_q);
		end
		if (cmd.glide) begin
			rem_q <= {1'b0, gel_new};
			dcnt_q <= 5'd16;
			tq_q <= '0;
			delta_q <= dtgt;
		end
		if (cmd.div_step) begin
			if (dcnt_q != 5'd0) begin
				if (div_ge2) begin
					rem_q <= rem_try2;
					tq_q <= {tq_q[15:0], 1'b1};
				end else begin
					rem_q <= rem_sh2;
					tq_q <= {tq_q[15:0], 1'b0};
				end
				dcnt_q <= dcnt_q - 5'd1;
			end
		end
		if (cmd.poly1) begin
			tt_q <= 34'(tq_q) * 34'(tq_q);
			ply_q <= 18'd196608 - {tq_q, 1'b0};
		end
		if (cmd.poly2) p_q <= 17'((52'(tt_q) * 52'(ply_q)) >> 32);
	end

	assign shown_angle = disp_q;
	assign step_value = cnt_q[saqg_pkg::StepW-1:0];

endmodule
`default_nettype wire

FILE: rtl/stepped_angle_quantizer_glide_core.sv
`default_nettype none
// Stepped angle quantizer with glide. Each input transfer carries a Q16 angle and an elapsed time;
// each produces one output transfer with the shown angle and the step count. An item goes
// through the release loop and the advance loop, one step at a time, then the product, the
// clamp and the glide update, then in glide mode, unless the glide has already ended, a
// bit-serial divider and the smoothstep blend, and last an output state that stretches while
// the previous output transfer is still waiting. The next input is taken from the cycle after
// that.
module stepped_angle_quantizer_glide_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // measured_angle, elapsed_us
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // shown_angle, step_value, zero fill
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	saqg_pkg::cmd_t cmd;
	saqg_pkg::sts_t sts;
	logic busy;
	logic out_free;
	logic signed [19:0] shown;
	logic signed [6:0] stepv;

	assign s_tready = !busy;
	assign out_free = !m_tvalid || m_tready;

	saqg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(s_tvalid && s_tready),
		.out_free(out_free), .sts(sts), .cmd(cmd), .busy(busy)
	);

	saqg_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.measured_angle(s_tdata[19:0]), .elapsed_us(s_tdata[39:20]),
		.shown_angle(shown), .step_value(stepv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) m_tdata <= {5'd0, stepv, shown};
	end

endmodule
`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps
module tb;

	typedef struct {
		logic signed [19:0] angle;
		logic [19:0] dt;
	} sample_t;

	typedef struct {
		logic signed [19:0] shown;
		logic signed [6:0] steps;
	} view_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [39:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	stepped_angle_quantizer_glide_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	sample_t pending[$];
	view_t views_due[$];
	int errors = 0;
	int send_idle = 0;
	int recv_stall = 0;

	// predictor copy of registers and state
	longint r_pdz, r_ptrig, r_ndz, r_ntrig, r_hyst, r_amt, r_maxx, r_dur;
	longint q_cnt, q_disp, q_start, q_tgt, q_elapsed;

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		errors++;
	endtask

	function automatic longint trig_for(input bit positive);
		longint t;
		t = positive ? r_ptrig : r_ntrig;
		return t < saqg_pkg::TrigMin ? saqg_pkg::TrigMin : t;
	endfunction

	function automatic longint mag(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic view_t glide_predict(input sample_t s);
		view_t v;
		longint a, sg, tr, hy, tgt, e, t, p, off;
		bit pos;
		a = s.angle;
		while (q_cnt != 0) begin
			pos = q_cnt > 0;
			sg = pos ? 1 : -1;
			tr = trig_for(pos);
			hy = r_hyst < tr * 9 / 10 ? r_hyst : tr * 9 / 10;
			if (a * sg < (pos ? r_pdz : r_ndz) + mag(q_cnt) * tr - hy)
				q_cnt -= sg;
			else
				break;
		end
		pos = a >= 0;
		sg = pos ? 1 : -1;
		tr = trig_for(pos);
		if (q_cnt == 0 || (q_cnt > 0) == pos)
			while (mag(q_cnt) < saqg_pkg::MaxSteps &&
				a * sg >= (pos ? r_pdz : r_ndz) + (mag(q_cnt) + 1) * tr)
				q_cnt += sg;
		tgt = q_cnt * r_amt;
		if (r_maxx > 0) begin
			if (tgt > r_maxx) tgt = r_maxx;
			if (tgt < -r_maxx) tgt = -r_maxx;
		end
		if (tgt > 524287) tgt = 524287;
		if (tgt < -524288) tgt = -524288;
		if (r_dur == 0) begin
			q_disp = tgt; q_start = tgt; q_tgt = tgt; q_elapsed = 0;
		end else begin
			if (tgt != q_tgt) begin
				q_start = q_disp; q_tgt = tgt; q_elapsed = 0;
			end
			e = q_elapsed + s.dt;
			if (e > r_dur) e = r_dur;
			q_elapsed = e;
			if (q_elapsed >= r_dur) q_disp = q_tgt;
			else begin
				t = (q_elapsed * 65536) / r_dur;
				p = longint'((64'(t) * 64'(t) * 64'(196608 - 2 * t)) >> 32);
				off = (q_tgt - q_start) * p / 65536;
				q_disp = q_start + off;
			end
		end
		v.shown = q_disp[19:0];
		v.steps = q_cnt[6:0];
		return v;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sample_t s;
				s.angle = s_tdata[19:0];
				s.dt = s_tdata[39:20];
				views_due.push_back(glide_predict(s));
			end
			if (!(s_tvalid && !s_tready)) begin
				if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
					sample_t n;
					n = pending.pop_front();
					s_tdata <= {n.dt, n.angle};
					s_tvalid <= 1'b1;
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (views_due.size() == 0)
					report("unexpected transfer", m_tdata, 0);
				else begin
					view_t w;
					w = views_due.pop_front();
					if (m_tdata[19:0] !== w.shown)
						report("shown_angle", $signed(m_tdata[19:0]), w.shown);
					if (m_tdata[26:20] !== w.steps)
						report("step_value", $signed(m_tdata[26:20]), w.steps);
					if (m_tdata[31:27] !== 5'd0)
						report("zero fill", m_tdata[31:27], 0);
				end
			end
			m_tready <= $urandom_range(99) >= recv_stall;
		end
	end

	task automatic write_reg(input saqg_pkg::reg_idx_t idx, input longint val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[23:0];
		case (idx)
			saqg_pkg::REG_POS_DZ: r_pdz = val & 'h7FFFF;
			saqg_pkg::REG_POS_TRIG: r_ptrig = val & 'h7FFFF;
			saqg_pkg::REG_NEG_DZ: r_ndz = val & 'h7FFFF;
			saqg_pkg::REG_NEG_TRIG: r_ntrig = val & 'h7FFFF;
			saqg_pkg::REG_HYST: r_hyst = val & 'h7FFFF;
			saqg_pkg::REG_STEP_AMT: r_amt = val & 'h7FFFF;
			saqg_pkg::REG_MAX_EXTRA: r_maxx = val & 'h7FFFF;
			default: r_dur = val & 'hFFFFFF;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		wait (pending.size() == 0 && !s_tvalid && views_due.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic add(input longint a, input longint d);
		sample_t s;
		s.angle = a[19:0];
		s.dt = d[19:0];
		pending.push_back(s);
	endtask

	task automatic program_set(input int mode);
		longint tr;
		tr = $urandom_range(0, 3) == 0 ? $urandom_range(0, 600) : $urandom_range(600, 20000);
		write_reg(saqg_pkg::REG_POS_DZ, mode == 2 ? 'h7FFFF : $urandom_range(0, 8000));
		write_reg(saqg_pkg::REG_POS_TRIG, mode == 1 ? 0 : tr);
		write_reg(saqg_pkg::REG_NEG_DZ, mode == 3 ? 'h7FFFF : $urandom_range(0, 8000));
		write_reg(saqg_pkg::REG_NEG_TRIG, mode == 1 ? 'h7FFFF : $urandom_range(0, 20000));
		write_reg(saqg_pkg::REG_HYST, mode == 2 ? 'hFFFFFF : $urandom_range(0, 16000));
		write_reg(saqg_pkg::REG_STEP_AMT, mode == 3 ? 'h7FFFF : $urandom_range(0, 30000));
		write_reg(saqg_pkg::REG_MAX_EXTRA,
			$urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 'h7FFFF));
		write_reg(saqg_pkg::REG_GLIDE_DUR, mode == 1 ? 'hFFFFFF : $urandom_range(0, 3) == 0 ? 0 :
			$urandom_range(1, 200000));
	endtask

	initial begin
		longint a;
		r_pdz = 0; r_ptrig = 6554; r_ndz = 0; r_ntrig = 6554;
		r_hyst = 0; r_amt = 6554; r_maxx = 0; r_dur = 0;
		q_cnt = 0; q_disp = 0; q_start = 0; q_tgt = 0; q_elapsed = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// reset values, instant mode, edges of the angle range
		add(0, 0); add(524287, 0); add(-524288, 'hFFFFF); add(6554, 1); add(-6554, 5);
		add(13000, 0); add(12000, 0); add(-1, 0);
		drain();
		write_reg(saqg_pkg::REG_GLIDE_DUR, 1000);
		write_reg(saqg_pkg::REG_HYST, 3000);
		write_reg(saqg_pkg::REG_MAX_EXTRA, 10000);
		// glide across retargets, saturation of the count
		add(20000, 100); add(20000, 300); add(20000, 'hFFFFF); add(-30000, 10);
		add(-30000, 999); add(5000, 0); add(524287, 50); add(-524288, 50);
		drain();
		for (int ph = 0; ph < 12; ph++) begin
			program_set(ph < 4 ? ph : 0);
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 46; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 46; end
				default: begin send_idle = 17; recv_stall = 17; end
			endcase
			a = 0;
			for (int k = 0; k < 50; k++) begin
				case ($urandom_range(0, 4))
					0: a = $signed(20'($urandom));
					1: a = -a;
					default: a = a + $signed(14'($urandom));
				endcase
				if (a > 524287) a = 524287;
				if (a < -524288) a = -524288;
				add(a, $urandom_range(0, 9) == 0 ? $urandom_range(0, 'hFFFFF) :
					$urandom_range(0, 20000));
			end
			drain();
		end
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#30ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
